[hw/rtl/lbps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbps_pkg
// shared types, codes and phase tables of the led blink pattern sequencer
// ----------------------------------------------------------------------------
package lbps_pkg;

    localparam int DEF_SLICE_MS = 20;

    localparam int SLICE_W = 5;
    localparam int PMS_W   = 11;
    localparam int BLINK_W = 16;

    // command codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_SET     = 3'd1;
    localparam logic [2:0] CMD_BLINK   = 3'd2;
    localparam logic [2:0] CMD_SUSPEND = 3'd3;
    localparam logic [2:0] CMD_RESUME  = 3'd4;

    // pattern codes
    localparam logic [2:0] PAT_OFF           = 3'd0;
    localparam logic [2:0] PAT_SOLID         = 3'd1;
    localparam logic [2:0] PAT_SEARCHING     = 3'd2;
    localparam logic [2:0] PAT_UPDATED       = 3'd3;
    localparam logic [2:0] PAT_FAIL          = 3'd4;
    localparam logic [2:0] PAT_UNPROVISIONED = 3'd5;
    localparam logic [2:0] PAT_RECOVERY      = 3'd6;
    localparam logic [2:0] PAT_INVALID       = 3'd7;

    // configuration register indexes
    localparam logic CFG_ACTIVE_LOW  = 1'b0;
    localparam logic CFG_PIN_PRESENT = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  pattern;
        logic [15:0] shot_ms;
        logic        bus_busy;
    } lbps_in_t;

    typedef struct packed {
        logic       pin_level;
        logic       is_suspended;
        logic [2:0] active_pattern;
    } lbps_out_t;

    typedef struct packed {
        logic pol_inv;
        logic pin_present;
    } lbps_cfg_t;

    function automatic logic [PMS_W-1:0] phase_dur(input logic [2:0] p, input logic [1:0] i);
        logic [PMS_W-1:0] d;
        d = '0;
        case (p)
            PAT_SOLID:         d = (i == 2'd0) ? 11'd20  : ((i == 2'd1) ? 11'd5 : 11'd0);
            PAT_SEARCHING:     d = (i == 2'd0) ? 11'd100 : ((i == 2'd1) ? 11'd900 : 11'd0);
            PAT_UPDATED:       d = (i[1] == 1'b0) ? 11'd100 : 11'd0;
            PAT_FAIL:          d = (i[1] == 1'b0) ? 11'd80 : 11'd0;
            PAT_UNPROVISIONED: d = (i == 2'd3) ? 11'd760 : 11'd80;
            PAT_RECOVERY:      d = (i == 2'd0) ? 11'd100 : ((i == 2'd1) ? 11'd1900 : 11'd0);
            default:           d = (i == 2'd0) ? 11'd500 : 11'd0;
        endcase
        return d;
    endfunction

    function automatic logic phase_lvl(input logic [2:0] p, input logic [1:0] i);
        logic l;
        l = 1'b0;
        case (p)
            PAT_OFF, PAT_INVALID: l = 1'b0;
            PAT_UNPROVISIONED:    l = (i == 2'd0) || (i == 2'd2);
            default:              l = (i == 2'd0);
        endcase
        return l;
    endfunction

    function automatic logic [2:0] phase_cnt(input logic [2:0] p);
        logic [2:0] c;
        c = 3'd2;
        case (p)
            PAT_OFF, PAT_INVALID: c = 3'd1;
            PAT_UNPROVISIONED:    c = 3'd4;
            default:              c = 3'd2;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] repeat_max(input logic [2:0] p);
        logic [2:0] r;
        r = 3'd1;
        case (p)
            PAT_UPDATED: r = 3'd3;
            PAT_FAIL:    r = 3'd5;
            default:     r = 3'd1;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lbps_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbps_core
// sequencer state and the combinational update for one input item
// ----------------------------------------------------------------------------
module lbps_core #(
    parameter int SLICE_MS = lbps_pkg::DEF_SLICE_MS
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 step_en,
    input  lbps_pkg::lbps_in_t  item,
    input  lbps_pkg::lbps_cfg_t cfg,
    output lbps_pkg::lbps_out_t result
);
    import lbps_pkg::*;

    localparam logic [PMS_W-1:0]   SLICE_P = PMS_W'(SLICE_MS);
    localparam logic [SLICE_W-1:0] SLICE_S = SLICE_W'(SLICE_MS);

    logic [2:0]         cur_reg, cur_next;
    logic [2:0]         run_reg, run_next;
    logic [1:0]         pidx_reg, pidx_next;
    logic [PMS_W-1:0]   pms_reg, pms_next;
    logic [SLICE_W-1:0] slc_reg, slc_next;
    logic [2:0]         rep_reg, rep_next;
    logic [BLINK_W-1:0] pend_reg, pend_next;
    logic [BLINK_W-1:0] blk_reg, blk_next;
    logic               susp_reg, susp_next;
    logic               pin_reg, pin_next;

    logic wr_ok;
    logic restart;
    logic phase_go;
    logic slice_go;

    function automatic logic [SLICE_W-1:0] slice_len(input logic [PMS_W-1:0] p);
        return (p < SLICE_P) ? p[SLICE_W-1:0] : SLICE_S;
    endfunction

    assign wr_ok = !susp_reg && cfg.pin_present && !item.bus_busy;

    always_comb begin
        cur_next  = cur_reg;
        run_next  = run_reg;
        pidx_next = pidx_reg;
        pms_next  = pms_reg;
        slc_next  = slc_reg;
        rep_next  = rep_reg;
        pend_next = pend_reg;
        blk_next  = blk_reg;
        susp_next = susp_reg;
        pin_next  = pin_reg;
        restart   = 1'b0;
        phase_go  = 1'b0;
        slice_go  = 1'b0;
        case (item.command)
            CMD_TICK: begin
                // idle sequencer starts the selected pattern
                if (blk_reg == '0 && slc_reg == '0) begin
                    run_next  = cur_reg;
                    pidx_next = 2'd0;
                    rep_next  = 3'd0;
                    pms_next  = phase_dur(cur_reg, 2'd0);
                    if (wr_ok) begin
                        pin_next = phase_lvl(cur_reg, 2'd0) ^ cfg.pol_inv;
                    end
                    if (pend_reg != '0) begin
                        blk_next  = pend_reg;
                        pend_next = '0;
                        if (wr_ok) begin
                            pin_next = !cfg.pol_inv;
                        end
                    end else begin
                        slc_next = slice_len(pms_next);
                    end
                end
                if (blk_next != '0) begin
                    blk_next = blk_next - BLINK_W'(1);
                    if (blk_next == '0) begin
                        if (wr_ok) begin
                            pin_next = cfg.pol_inv;
                        end
                        slc_next = slice_len(pms_next);
                    end
                end else if (slc_next != '0) begin
                    slc_next = slc_next - SLICE_W'(1);
                    if (pms_next != '0) begin
                        pms_next = pms_next - PMS_W'(1);
                    end
                    if (slc_next == '0) begin
                        if (cur_next != run_next) begin
                            restart = 1'b1;
                        end else if (pms_next == '0) begin
                            if ({1'b0, pidx_next} + 3'd1 < phase_cnt(run_next)) begin
                                pidx_next = pidx_next + 2'd1;
                                phase_go  = 1'b1;
                            end else if (rep_next + 3'd1 < repeat_max(run_next)) begin
                                rep_next  = rep_next + 3'd1;
                                pidx_next = 2'd0;
                                phase_go  = 1'b1;
                            end else begin
                                if (run_next == PAT_UPDATED) begin
                                    cur_next = PAT_SOLID;
                                end else if (run_next == PAT_FAIL) begin
                                    cur_next = PAT_OFF;
                                end
                                restart = 1'b1;
                            end
                        end else begin
                            slice_go = 1'b1;
                        end
                    end
                end
                if (restart) begin
                    run_next  = cur_next;
                    pidx_next = 2'd0;
                    rep_next  = 3'd0;
                    phase_go  = 1'b1;
                end
                if (phase_go) begin
                    if (wr_ok) begin
                        pin_next = phase_lvl(run_next, pidx_next) ^ cfg.pol_inv;
                    end
                    pms_next = phase_dur(run_next, pidx_next);
                    slice_go = 1'b1;
                end
                if (slice_go) begin
                    if (pend_next != '0) begin
                        blk_next  = pend_next;
                        pend_next = '0;
                        if (wr_ok) begin
                            pin_next = !cfg.pol_inv;
                        end
                    end else begin
                        slc_next = slice_len(pms_next);
                    end
                end
            end
            CMD_SET: begin
                if (item.pattern != PAT_INVALID) begin
                    cur_next = item.pattern;
                end
            end
            CMD_BLINK: begin
                if (item.shot_ms != '0) begin
                    pend_next = item.shot_ms;
                end
            end
            CMD_SUSPEND: begin
                if (cfg.pin_present && !susp_reg) begin
                    pin_next  = cfg.pol_inv;
                    susp_next = 1'b1;
                end
            end
            CMD_RESUME: begin
                if (cfg.pin_present && susp_reg) begin
                    pin_next  = cfg.pol_inv;
                    susp_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= PAT_OFF;
            run_reg  <= PAT_OFF;
            pidx_reg <= '0;
            pms_reg  <= '0;
            slc_reg  <= '0;
            rep_reg  <= '0;
            pend_reg <= '0;
            blk_reg  <= '0;
            susp_reg <= 1'b0;
            pin_reg  <= 1'b0;
        end else if (step_en) begin
            cur_reg  <= cur_next;
            run_reg  <= run_next;
            pidx_reg <= pidx_next;
            pms_reg  <= pms_next;
            slc_reg  <= slc_next;
            rep_reg  <= rep_next;
            pend_reg <= pend_next;
            blk_reg  <= blk_next;
            susp_reg <= susp_next;
            pin_reg  <= pin_next;
        end
    end

    assign result.pin_level      = pin_next;
    assign result.is_suspended   = susp_next;
    assign result.active_pattern = cur_next;

endmodule
`default_nettype wire

[hw/rtl/led_blink_pattern_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer
// plays led blink patterns from millisecond ticks and control events
//
// s_ channel: one item per tick or event (command, pattern, shot_ms,
// bus_busy), taken on s_valid and s_ready.
// m_ channel: exactly one result per item (pin_level, is_suspended,
// active_pattern), in input order, on m_valid and m_ready.
// cfg_we writes register cfg_index (0 pol_inv, 1 pin_present) from
// cfg_data; write only while no item is in flight.
// path: an item is held in the input register, then its result in the
// result register, from which it is shown.
// throughput: one item per cycle while m_ready is high; the whole update
// of the sequencer state is a single pass of logic between the two registers.
// reset: pattern off, nothing pending, not suspended, pin level 0,
// pol_inv 1, pin_present 0; both channels empty.
// stall: while m_ready is low the result is held; one more item is taken
// into the input register, then s_ready drops until the result transfers.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer #(
    parameter int SLICE_MS = lbps_pkg::DEF_SLICE_MS
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  lbps_pkg::lbps_in_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output lbps_pkg::lbps_out_t m_data,
    input  wire                 cfg_we,
    input  wire                 cfg_index,
    input  wire                 cfg_data
);
    import lbps_pkg::*;

    lbps_in_t  in_reg;
    logic      in_valid_reg;
    lbps_out_t out_reg;
    logic      out_valid_reg;
    lbps_cfg_t cfg_reg;
    lbps_out_t step_result;
    logic      out_free;
    logic      advance;
    logic      in_take;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    lbps_core #(
        .SLICE_MS(SLICE_MS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            cfg_reg.pol_inv     <= 1'b1;
            cfg_reg.pin_present <= 1'b0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ACTIVE_LOW:  cfg_reg.pol_inv     <= cfg_data;
                    CFG_PIN_PRESENT: cfg_reg.pin_present <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire
